// ===== rtl/ssplit_pkg.sv =====
// Shared types and constants for the span segment splitter.
package ssplit_pkg;

   localparam int REQ_BITS        = 2;
   localparam int ENTRY_SIZE_BITS = 40;
   localparam int OFFSET_BITS     = 44;
   localparam int STATUS_BITS     = 3;
   localparam int INDEX_BITS      = 4;
   localparam int EOFF_BITS       = 40;
   localparam int SEG_BITS        = 41;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_BITS        = $clog2(MAX_RESULTS);

   localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_SPLIT  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_SEGMENT    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ACK        = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_TABLE_FULL = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_OUT_RANGE  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY      = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPAN_END,
      ST_READ,
      ST_END,
      ST_LOW,
      ST_HIGH,
      ST_TAIL,
      ST_SEG,
      ST_EMIT,
      ST_DONE_UPD,
      ST_POS_UPD
   } state_type;

   typedef struct packed {
      logic borrow;
      logic zero;
   } alu_flags_type;

endpackage

// ===== rtl/span_segment_splitter_top.sv =====
// Span segment splitter: extent table, sequencer and shared adder.
// Clear, append, empty span and split on an empty table: one item, shown the cycle after
// the accepting edge; busy stays low, so such items may follow every cycle.
// A split finds the span end, then reads each entry and checks its end and bounds up to
// the hit, then forms and emits each segment; busy falls as the last item appears.
// One shared add/subtract unit, one registered table read. Sync reset empties the table.
module span_segment_splitter_top import ssplit_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int SIZE_BITS   = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [REQ_BITS-1:0]        req_type,
   input  logic [ENTRY_SIZE_BITS-1:0] req_entry_size,
   input  logic                       req_entry_included,
   input  logic [OFFSET_BITS-1:0]     req_start_offset,
   input  logic [OFFSET_BITS-1:0]     req_span_length,
   input  logic                       req_is_write,
   output logic                       rsp_valid,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [INDEX_BITS-1:0]      rsp_entry_index,
   output logic [EOFF_BITS-1:0]       rsp_entry_offset,
   output logic [SEG_BITS-1:0]        rsp_seg_length,
   output logic [OFFSET_BITS-1:0]     rsp_buffer_offset,
   output logic                       rsp_seg_included,
   output logic                       rsp_write_dir,
   output logic                       rsp_last
);

   // Datapath width: start offset plus an entry size, with one carry bit.
   localparam int SUM_BITS  = ((SIZE_BITS > OFFSET_BITS) ? SIZE_BITS : OFFSET_BITS) + 1;
   localparam int ADDR_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_BITS  = (SIZE_BITS > ENTRY_SIZE_BITS) ? SIZE_BITS : ENTRY_SIZE_BITS;

   // Sequencer and table bookkeeping
   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [OFFSET_BITS-1:0]  total_ff, total_in;
   logic [CNT_BITS-1:0]     cur_ff, cur_in;
   logic [RES_BITS-1:0]     nres_ff, nres_in;
   logic                    seg_phase_ff, seg_phase_in;

   // Per-request working registers
   logic [OFFSET_BITS-1:0]  s_ff, s_in;
   logic [OFFSET_BITS-1:0]  len_ff, len_in;
   logic                    dir_ff, dir_in;
   logic [SUM_BITS-1:0]     span_end_ff, span_end_in;
   logic [SUM_BITS-1:0]     endx_ff, endx_in;
   logic [SUM_BITS-1:0]     pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]  done_ff, done_in;
   logic [OFFSET_BITS-1:0]  seg_ff, seg_in;
   logic                    lo_ok_ff, lo_ok_in;
   logic                    tail_ff, tail_in;
   logic                    end_eq_ff, end_eq_in;

   // Result registers
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]   rsp_index_ff, rsp_index_in;
   logic [EOFF_BITS-1:0]    rsp_eoff_ff, rsp_eoff_in;
   logic [SEG_BITS-1:0]     rsp_seg_ff, rsp_seg_in;
   logic [OFFSET_BITS-1:0]  rsp_boff_ff, rsp_boff_in;
   logic                    rsp_inc_ff, rsp_inc_in;
   logic                    rsp_dir_ff, rsp_dir_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Shared unit
   logic [SUM_BITS-1:0]     alu_a, alu_b, alu_res;
   logic                    alu_sub;
   alu_flags_type           alu_flags;

   // Table ports
   logic                    tbl_wr_en;
   logic [OFFSET_BITS-1:0]  tbl_start;
   logic [SIZE_BITS-1:0]    tbl_size;
   logic                    tbl_include;

   logic                    accept;
   logic [EXT_BITS-1:0]     size_ext;
   logic [SIZE_BITS-1:0]    size_trunc;
   logic [CNT_BITS-1:0]     cur_next;
   logic                    table_end;
   logic                    hit;
   logic                    seg_last;

   assign accept     = start && (state_ff == ST_IDLE);
   assign size_ext   = EXT_BITS'(req_entry_size);
   assign size_trunc = size_ext[SIZE_BITS-1:0];
   assign cur_next   = cur_ff + 1'b1;
   assign table_end  = (cur_next >= count_ff);
   assign hit        = (tbl_size != '0) && lo_ok_ff && alu_flags.borrow;
   // Span covered, table exhausted or result budget spent.
   assign seg_last   = !tail_ff || end_eq_ff || table_end ||
                       (nres_ff == RES_BITS'(MAX_RESULTS - 1));

   ssplit_alu #(
      .WIDTH (SUM_BITS)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .flags  (alu_flags)
   );

   ssplit_table #(
      .DEPTH     (MAX_ENTRIES),
      .ADDR_BITS (ADDR_BITS),
      .SIZE_BITS (SIZE_BITS)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_wr_en),
      .wr_addr    (count_ff[ADDR_BITS-1:0]),
      .wr_start   (total_ff),
      .wr_size    (size_trunc),
      .wr_include (req_entry_included),
      .rd_addr    (cur_ff[ADDR_BITS-1:0]),
      .rd_start   (tbl_start),
      .rd_size    (tbl_size),
      .rd_include (tbl_include)
   );

   // Operand selection for the shared unit
   always_comb begin
      alu_a   = SUM_BITS'(total_ff);
      alu_b   = SUM_BITS'(size_trunc);
      alu_sub = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            alu_a   = SUM_BITS'(total_ff);
            alu_b   = SUM_BITS'(size_trunc);
            alu_sub = 1'b0;
         end
         ST_SPAN_END: begin
            alu_a   = SUM_BITS'(s_ff);
            alu_b   = SUM_BITS'(len_ff);
            alu_sub = 1'b0;
         end
         ST_END: begin
            alu_a   = SUM_BITS'(tbl_start);
            alu_b   = SUM_BITS'(tbl_size);
            alu_sub = 1'b0;
         end
         ST_LOW: begin
            alu_a   = SUM_BITS'(s_ff);
            alu_b   = SUM_BITS'(tbl_start);
            alu_sub = 1'b1;
         end
         ST_HIGH: begin
            alu_a   = SUM_BITS'(s_ff);
            alu_b   = endx_ff;
            alu_sub = 1'b1;
         end
         ST_TAIL: begin
            alu_a   = span_end_ff;
            alu_b   = endx_ff;
            alu_sub = 1'b1;
         end
         ST_SEG: begin
            alu_sub = 1'b1;
            if (tail_ff) begin
               alu_a = endx_ff;
               alu_b = pos_ff;
            end else begin
               alu_a = SUM_BITS'(len_ff);
               alu_b = SUM_BITS'(done_ff);
            end
         end
         ST_EMIT: begin
            alu_a   = pos_ff;
            alu_b   = SUM_BITS'(tbl_start);
            alu_sub = 1'b1;
         end
         ST_DONE_UPD: begin
            alu_a   = SUM_BITS'(done_ff);
            alu_b   = SUM_BITS'(seg_ff);
            alu_sub = 1'b0;
         end
         ST_POS_UPD: begin
            alu_a   = pos_ff;
            alu_b   = SUM_BITS'(seg_ff);
            alu_sub = 1'b0;
         end
         default: begin
            alu_a   = SUM_BITS'(total_ff);
            alu_b   = SUM_BITS'(size_trunc);
            alu_sub = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      cur_in        = cur_ff;
      nres_in       = nres_ff;
      seg_phase_in  = seg_phase_ff;
      s_in          = s_ff;
      len_in        = len_ff;
      dir_in        = dir_ff;
      span_end_in   = span_end_ff;
      endx_in       = endx_ff;
      pos_in        = pos_ff;
      done_in       = done_ff;
      seg_in        = seg_ff;
      lo_ok_in      = lo_ok_ff;
      tail_in       = tail_ff;
      end_eq_in     = end_eq_ff;
      tbl_wr_en     = 1'b0;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_eoff_in   = rsp_eoff_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_boff_in   = rsp_boff_ff;
      rsp_inc_in    = rsp_inc_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Single-item answers; fields not used by them read zero.
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_ACK;
               rsp_index_in  = '0;
               rsp_eoff_in   = '0;
               rsp_seg_in    = '0;
               rsp_boff_in   = '0;
               rsp_inc_in    = 1'b0;
               rsp_dir_in    = 1'b0;
               rsp_last_in   = 1'b1;
               case (req_type)
                  REQ_APPEND: begin
                     if (count_ff >= CNT_BITS'(MAX_ENTRIES)) begin
                        rsp_status_in = STATUS_TABLE_FULL;
                     end else begin
                        tbl_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                        total_in  = alu_res[OFFSET_BITS-1:0];
                     end
                  end
                  REQ_SPLIT: begin
                     rsp_dir_in = req_is_write;
                     if (req_span_length == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (count_ff == '0) begin
                        rsp_status_in = STATUS_OUT_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        s_in         = req_start_offset;
                        len_in       = req_span_length;
                        dir_in       = req_is_write;
                        pos_in       = SUM_BITS'(req_start_offset);
                        done_in      = '0;
                        cur_in       = '0;
                        nres_in      = '0;
                        seg_phase_in = 1'b0;
                        state_in     = ST_SPAN_END;
                     end
                  end
                  default: begin
                     count_in = '0;
                     total_in = '0;
                  end
               endcase
            end
         end
         ST_SPAN_END: begin
            span_end_in = alu_res;
            state_in    = ST_READ;
         end
         ST_READ: begin
            // table read for cur is registered at the end of this state; the data is valid in ST_END
            state_in = ST_END;
         end
         ST_END: begin
            endx_in  = alu_res;
            state_in = seg_phase_ff ? ST_TAIL : ST_LOW;
         end
         ST_LOW: begin
            lo_ok_in = !alu_flags.borrow;
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            if (hit) begin
               seg_phase_in = 1'b1;
               state_in     = ST_TAIL;
            end else if (table_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OUT_RANGE;
               rsp_index_in  = '0;
               rsp_eoff_in   = '0;
               rsp_seg_in    = '0;
               rsp_boff_in   = '0;
               rsp_inc_in    = 1'b0;
               rsp_dir_in    = dir_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cur_in   = cur_next;
               state_in = ST_READ;
            end
         end
         ST_TAIL: begin
            // span reaches the entry end; equal ends mean this segment closes it
            tail_in   = !alu_flags.borrow;
            end_eq_in = alu_flags.zero;
            state_in  = ST_SEG;
         end
         ST_SEG: begin
            if (tail_ff && (alu_flags.borrow || alu_flags.zero)) begin
               seg_in = '0;
            end else begin
               seg_in = alu_res[OFFSET_BITS-1:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_SEGMENT;
            rsp_index_in  = INDEX_BITS'(cur_ff);
            rsp_eoff_in   = alu_res[EOFF_BITS-1:0];
            rsp_seg_in    = seg_ff[SEG_BITS-1:0];
            rsp_boff_in   = done_ff;
            rsp_inc_in    = tbl_include;
            rsp_dir_in    = dir_ff;
            rsp_last_in   = seg_last;
            nres_in       = nres_ff + 1'b1;
            state_in      = seg_last ? ST_IDLE : ST_DONE_UPD;
         end
         ST_DONE_UPD: begin
            done_in  = alu_res[OFFSET_BITS-1:0];
            state_in = ST_POS_UPD;
         end
         ST_POS_UPD: begin
            pos_in   = alu_res;
            cur_in   = cur_next;
            state_in = ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      nres_ff       <= nres_in;
      seg_phase_ff  <= seg_phase_in;
      s_ff          <= s_in;
      len_ff        <= len_in;
      dir_ff        <= dir_in;
      span_end_ff   <= span_end_in;
      endx_ff       <= endx_in;
      pos_ff        <= pos_in;
      done_ff       <= done_in;
      seg_ff        <= seg_in;
      lo_ok_ff      <= lo_ok_in;
      tail_ff       <= tail_in;
      end_eq_ff     <= end_eq_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_eoff_ff   <= rsp_eoff_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_boff_ff   <= rsp_boff_in;
      rsp_inc_ff    <= rsp_inc_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = rsp_index_ff;
   assign rsp_entry_offset  = rsp_eoff_ff;
   assign rsp_seg_length    = rsp_seg_ff;
   assign rsp_buffer_offset = rsp_boff_ff;
   assign rsp_seg_included  = rsp_inc_ff;
   assign rsp_write_dir     = rsp_dir_ff;
   assign rsp_last          = rsp_last_ff;

   // Final item of a request coincides with the sequencer being free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last item shown while sequencer still busy");

   // A non-final item only comes from a split still in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final item with sequencer idle");

   // Entry count never passes the table depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   // A split with a nonempty span over a nonempty table starts the walk.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == REQ_SPLIT) && (req_span_length != '0) &&
      (count_ff != '0) |=> busy && !rsp_valid)
      else $error("split did not start the table walk");

endmodule

// ===== rtl/ssplit_alu.sv =====
// Shared add/subtract unit with borrow and zero flags.
module ssplit_alu import ssplit_pkg::*; #(
   parameter int WIDTH = 49
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             sub,
   output logic [WIDTH-1:0] result,
   output alu_flags_type    flags
);

   logic [WIDTH:0] full;

   always_comb begin
      if (sub) begin
         full = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         full = {1'b0, op_a} + {1'b0, op_b};
      end
   end

   assign result       = full[WIDTH-1:0];
   assign flags.borrow = sub & full[WIDTH];
   assign flags.zero   = (full[WIDTH-1:0] == '0);

endmodule

// ===== rtl/ssplit_table.sv =====
// Extent table memory: one write port, one registered read port.
module ssplit_table import ssplit_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int SIZE_BITS = 40
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [OFFSET_BITS-1:0] wr_start,
   input  logic [SIZE_BITS-1:0]   wr_size,
   input  logic                   wr_include,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output logic [OFFSET_BITS-1:0] rd_start,
   output logic [SIZE_BITS-1:0]   rd_size,
   output logic                   rd_include
);

   logic [OFFSET_BITS-1:0] start_mem [DEPTH];
   logic [SIZE_BITS-1:0]   size_mem [DEPTH];
   logic                   include_mem [DEPTH];

   logic [OFFSET_BITS-1:0] rd_start_ff;
   logic [SIZE_BITS-1:0]   rd_size_ff;
   logic                   rd_include_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr]   <= wr_start;
         size_mem[wr_addr]    <= wr_size;
         include_mem[wr_addr] <= wr_include;
      end
   end

   always_ff @(posedge clock) begin
      rd_start_ff   <= start_mem[rd_addr];
      rd_size_ff    <= size_mem[rd_addr];
      rd_include_ff <= include_mem[rd_addr];
   end

   assign rd_start   = rd_start_ff;
   assign rd_size    = rd_size_ff;
   assign rd_include = rd_include_ff;

endmodule
